>>> design/fwts_pkg.sv
// shared types and constants of the four-wheel trace speed controller
package fwts_pkg;

  localparam int WHEELS  = 4;
  localparam int ERR_W   = 24;
  localparam int SPD_W   = 27;
  localparam int GAIN_W  = 24;
  localparam int TNOW_W  = 26;
  localparam int TPREV_W = 25;
  localparam int COMP_W  = 32;
  localparam int DUTY_W  = 14;
  localparam int ACC_W   = 40;
  localparam int SCALE_W = 17;

  localparam logic [ERR_W-1:0] TRACE_THR = 24'd239207;
  localparam logic [24:0] RECIP_120 = 25'd17895698;
  localparam logic [28:0] RECIP_17 = 29'd505290271;
  localparam logic signed [ACC_W:0] ACC_LIM = 41'sd549755813887;

  localparam logic [1:0] MODE_ALT = 2'd0;
  localparam logic [1:0] MODE_FWD = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRACE,
    S_LANE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_BASE,
    REG_FLOOR,
    REG_CEIL,
    REG_KP,
    REG_KI,
    REG_KD,
    REG_TNOW,
    REG_TPREV
  } reg_idx_t;

  typedef struct packed {
    logic [TNOW_W-1:0]  g_now;
    logic [TPREV_W-1:0] g_prev;
  } gains_t;

  typedef struct packed {
    logic              hit;
    logic              pos;
    logic [COMP_W-1:0] inner;
    logic [COMP_W-1:0] outer;
  } trace_res_t;

endpackage

>>> design/four_wheel_trace_speed_pid_core.sv
// top level of the four-wheel line-trace speed controller
// use: one item per control tick carries the tracking error, the drive
// pattern mode and the four measured wheel speeds; one result item gives the
// four pwm duties and the direction bits
// channels: in_ and out_ are valid/ready; settings are written over the apb
// port, register i at byte address 4*i; the user must write them only while
// the block is idle, which the block itself does not enforce
// the trace stage runs four pipeline steps and a three-step divide by ten of
// the outer compensation, the wheel lanes a three-step divide by ten of the
// accumulator step; the lane results are then gathered and loaded
// items: one at a time, a new item is taken the cycle after the previous
// result is loaded
// receiver stall: the result holds in the output register and the finished
// lanes wait until it is taken, holding off the input
// reset: settings, trace and speed history and accumulators clear, the
// direction pattern goes all high, no result is pending
module four_wheel_trace_speed_pid_core #(
  parameter int DUTY_MAX = 10000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] in_track_error,
  input  logic [1:0]  in_mode,
  input  logic signed [26:0] in_wheel_speed_0,
  input  logic signed [26:0] in_wheel_speed_1,
  input  logic signed [26:0] in_wheel_speed_2,
  input  logic signed [26:0] in_wheel_speed_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_duty_0,
  output logic [13:0] out_duty_1,
  output logic [13:0] out_duty_2,
  output logic [13:0] out_duty_3,
  output logic [3:0]  out_direction_bits
);
  localparam int W = fwts_pkg::WHEELS;

  logic signed [26:0] base_r, floor_r, ceil_r;
  logic [23:0]        kp_r, ki_r, kd_r;
  logic [25:0]        tnow_r;
  logic signed [24:0] tprev_r;

  fwts_pkg::state_t   state_r, state_nxt;
  logic [3:0]         pin_r;
  logic signed [26:0] spd_r [W];
  logic [13:0]        duty_out_r [W];
  logic [3:0]         dir_out_r;
  logic               out_valid_r;

  logic               wr_en;
  fwts_pkg::reg_idx_t widx;
  logic               accept;
  logic               trace_done;
  logic               lane_start;
  logic               load_out;
  fwts_pkg::trace_res_t tres;
  fwts_pkg::gains_t   tgains, sgains;
  logic signed [26:0] spd_in [W];
  logic signed [26:0] tgt [W];
  logic [W-1:0]       lane_done;
  logic [13:0]        lane_duty [W];

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = fwts_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      floor_r <= '0;
      ceil_r  <= '0;
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      tnow_r  <= '0;
      tprev_r <= '0;
    end else if (wr_en) begin
      unique case (widx)
        fwts_pkg::REG_BASE:  base_r  <= pwdata[26:0];
        fwts_pkg::REG_FLOOR: floor_r <= pwdata[26:0];
        fwts_pkg::REG_CEIL:  ceil_r  <= pwdata[26:0];
        fwts_pkg::REG_KP:    kp_r    <= pwdata[23:0];
        fwts_pkg::REG_KI:    ki_r    <= pwdata[23:0];
        fwts_pkg::REG_KD:    kd_r    <= pwdata[23:0];
        fwts_pkg::REG_TNOW:  tnow_r  <= pwdata[25:0];
        fwts_pkg::REG_TPREV: tprev_r <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      fwts_pkg::REG_BASE:  prdata = 32'(base_r);
      fwts_pkg::REG_FLOOR: prdata = 32'(floor_r);
      fwts_pkg::REG_CEIL:  prdata = 32'(ceil_r);
      fwts_pkg::REG_KP:    prdata = {8'd0, kp_r};
      fwts_pkg::REG_KI:    prdata = {8'd0, ki_r};
      fwts_pkg::REG_KD:    prdata = {8'd0, kd_r};
      fwts_pkg::REG_TNOW:  prdata = {6'd0, tnow_r};
      fwts_pkg::REG_TPREV: prdata = 32'(tprev_r);
      default:             prdata = '0;
    endcase
  end

  assign tgains.g_now  = tnow_r;
  assign tgains.g_prev = tprev_r;
  assign sgains.g_now  = 26'(kp_r) + 26'(ki_r) + 26'(kd_r);
  assign sgains.g_prev = 25'(ki_r) - 25'(kd_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fwts_pkg::S_IDLE:  if (accept) state_nxt = fwts_pkg::S_TRACE;
      fwts_pkg::S_TRACE: if (trace_done) state_nxt = fwts_pkg::S_LANE;
      fwts_pkg::S_LANE:  if (&lane_done) state_nxt = fwts_pkg::S_DONE;
      fwts_pkg::S_DONE:  if (load_out) state_nxt = fwts_pkg::S_IDLE;
      default:           state_nxt = fwts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = state_r == fwts_pkg::S_IDLE;
    lane_start = (state_r == fwts_pkg::S_TRACE) && trace_done;
    load_out   = (state_r == fwts_pkg::S_DONE) && (!out_valid_r || out_ready);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwts_pkg::S_IDLE;
      pin_r       <= 4'hF;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_mode == fwts_pkg::MODE_ALT) begin
          pin_r <= 4'h5;
        end else if (in_mode == fwts_pkg::MODE_FWD) begin
          pin_r <= 4'hF;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign spd_in[0] = in_wheel_speed_0;
  assign spd_in[1] = in_wheel_speed_1;
  assign spd_in[2] = in_wheel_speed_2;
  assign spd_in[3] = in_wheel_speed_3;

  always_ff @(posedge clk) begin
    if (accept) begin
      spd_r <= spd_in;
    end
    if (load_out) begin
      duty_out_r <= lane_duty;
      dir_out_r  <= pin_r;
    end
  end

  fwts_trace u_trace (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .err   (in_track_error),
    .gains (tgains),
    .done  (trace_done),
    .res   (tres)
  );

  for (genvar i = 0; i < W; i++) begin : g_lane
    logic               inner_sel;
    logic signed [31:0] comp;
    logic signed [32:0] raw;
    logic signed [32:0] lo;

    assign inner_sel = (i < W / 2) ? tres.pos : !tres.pos;
    assign comp = !tres.hit ? 32'sd0 : (inner_sel ? tres.inner : tres.outer);
    assign raw  = 33'(base_r) + 33'(comp);
    assign lo   = (raw < 33'(floor_r)) ? 33'(floor_r) : raw;
    assign tgt[i] = (lo > 33'(ceil_r)) ? ceil_r : lo[26:0];

    fwts_lane #(.DUTY_MAX(DUTY_MAX)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (lane_start),
      .target (tgt[i]),
      .meas   (spd_r[i]),
      .gains  (sgains),
      .done   (lane_done[i]),
      .duty   (lane_duty[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_duty_0         = duty_out_r[0];
  assign out_duty_1         = duty_out_r[1];
  assign out_duty_2         = duty_out_r[2];
  assign out_duty_3         = duty_out_r[3];
  assign out_direction_bits = dir_out_r;
endmodule

>>> design/fwts_div10.sv
// divider by ten, sixteen quotient bits per cycle by reciprocal multiply
module fwts_div10 #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int NCH = (W + 15) / 16;
  localparam int PW  = NCH * 16;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic [19:0] RECIP_10 = 20'd838861;

  logic [PW-1:0] x_r;
  logic [PW-1:0] q_r;
  logic [3:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [19:0]   v;
  logic [39:0]   prod;
  logic [15:0]   qd;
  logic [19:0]   q10;

  // remainder and next 16-bit chunk, divided by reciprocal
  assign v    = {rem_r, x_r[PW-1 -: 16]};
  assign prod = {20'd0, v} * {20'd0, RECIP_10};
  assign qd   = prod[38:23];
  assign q10  = {1'b0, qd, 3'b0} + {3'b0, qd, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NCH);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= PW'(dividend);
      q_r   <= '0;
      rem_r <= 4'd0;
    end else if (run_r) begin
      x_r   <= x_r << 16;
      q_r   <= (q_r << 16) | PW'(qd);
      rem_r <= 4'(v - q10);
    end
  end

  assign done     = done_r;
  assign quotient = q_r[W-1:0];
endmodule

>>> design/fwts_trace.sv
// shared trace term: scaled error, incremental pi-d and pair compensations
module fwts_trace (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [fwts_pkg::ERR_W-1:0]   err,
  input  fwts_pkg::gains_t                    gains,
  output logic                                done,
  output fwts_pkg::trace_res_t                res
);
  logic [fwts_pkg::ERR_W-1:0]   abs_r;
  logic                         hit_r;
  logic                         pos_r;
  logic [fwts_pkg::SCALE_W-1:0] s_r;
  logic [fwts_pkg::SCALE_W-1:0] prev_r;
  logic signed [44:0]           m1_r;
  logic signed [44:0]           m2_r;
  logic signed [28:0]           c_r;
  logic signed [31:0]           inner_r;
  logic                         neg_r;
  logic [31:0]                  outer_r;
  logic                         v1_r, v2_r, v3_r, v4_r, done_r;

  logic [fwts_pkg::ERR_W-1:0] abs_w;
  logic [48:0]                prod_s;
  logic signed [44:0]         m1_w, m2_w, sum_w;
  logic signed [31:0]         n3_w;
  logic signed [35:0]         x23_w;
  logic [35:0]                mag_w;
  logic                       div_done;
  logic [35:0]                div_q;

  assign abs_w  = err[fwts_pkg::ERR_W-1] ? fwts_pkg::ERR_W'(-err) : err;
  assign prod_s = {25'd0, abs_r} * {24'd0, fwts_pkg::RECIP_120};
  assign m1_w   = $signed({1'b0, gains.g_now}) * $signed({1'b0, s_r});
  assign m2_w   = $signed(gains.g_prev) * $signed({1'b0, prev_r});
  assign sum_w  = m1_r + m2_r;
  assign n3_w   = 32'(c_r) * -32'sd3;
  assign x23_w  = 36'(c_r) * 36'sd23;
  assign mag_w  = x23_w[35] ? 36'(-x23_w + 36'sd9) : x23_w;

  fwts_div10 #(.W(36)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (v4_r),
    .dividend (mag_w),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      done_r <= 1'b0;
      prev_r <= '0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      done_r <= div_done;
      if (v3_r && hit_r) begin
        prev_r <= s_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      abs_r <= abs_w;
      hit_r <= abs_w >= fwts_pkg::TRACE_THR;
      pos_r <= !err[fwts_pkg::ERR_W-1] && (err != '0);
    end
    if (v1_r) begin
      s_r <= prod_s[47:31];
    end
    if (v2_r) begin
      m1_r <= m1_w;
      m2_r <= m2_w;
    end
    if (v3_r) begin
      c_r <= sum_w[44:16];
    end
    if (v4_r) begin
      inner_r <= n3_w >>> 1;
      neg_r   <= x23_w[35];
    end
    if (div_done) begin
      outer_r <= neg_r ? 32'(-div_q) : div_q[31:0];
    end
  end

  assign done      = done_r;
  assign res.hit   = hit_r;
  assign res.pos   = pos_r;
  assign res.inner = inner_r;
  assign res.outer = outer_r;
endmodule

>>> design/fwts_lane.sv
// one wheel lane: incremental speed pid, accumulator and duty
module fwts_lane #(
  parameter int DUTY_MAX = 10000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [fwts_pkg::SPD_W-1:0]  target,
  input  logic signed [fwts_pkg::SPD_W-1:0]  meas,
  input  fwts_pkg::gains_t                   gains,
  output logic                               done,
  output logic [fwts_pkg::DUTY_W-1:0]        duty
);
  localparam logic [22:0] DMAX = 23'(DUTY_MAX);

  logic signed [27:0]               e_r;
  logic signed [27:0]               prev_r;
  logic signed [54:0]               m1_r, m2_r;
  logic signed [fwts_pkg::ACC_W-1:0] acc_r;
  logic                             neg_r;
  logic [26:0]                      t_r;
  logic [fwts_pkg::DUTY_W-1:0]      duty_r;
  logic                             v1_r, v2_r, v4_r, v5_r, done_r;

  logic signed [27:0] at_w, am_w;
  logic signed [54:0] m1_w, m2_w, sum_w;
  logic signed [42:0] x7_w;
  logic [42:0]        mag_w;
  logic               div_done;
  logic [42:0]        div_q;
  logic signed [43:0] q_w, acc_sum;
  logic [38:0]        a_w;
  logic [42:0]        a10_w;
  logic [55:0]        p_w;
  logic [22:0]        d_w;

  assign at_w  = target[fwts_pkg::SPD_W-1] ? -28'(target) : 28'(target);
  assign am_w  = meas[fwts_pkg::SPD_W-1] ? -28'(meas) : 28'(meas);
  assign m1_w  = $signed({1'b0, gains.g_now}) * e_r;
  assign m2_w  = $signed(gains.g_prev) * prev_r;
  assign sum_w = m1_r + m2_r;
  assign x7_w  = 43'($signed(sum_w[54:16])) * 43'sd7;
  assign mag_w = x7_w[42] ? 43'(-x7_w + 43'sd9) : x7_w;
  assign q_w   = neg_r ? -44'(div_q) : 44'(div_q);
  assign acc_sum = 44'(acc_r) + q_w;
  assign a_w   = acc_r[fwts_pkg::ACC_W-1] ? 39'(-acc_r) : acc_r[38:0];
  assign a10_w = {4'd0, a_w} * 43'd10;
  assign p_w   = {29'd0, t_r} * {27'd0, fwts_pkg::RECIP_17};
  assign d_w   = p_w[55:33];

  fwts_div10 #(.W(43)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (v2_r),
    .dividend (mag_w),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      done_r <= 1'b0;
      prev_r <= '0;
      acc_r  <= '0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v4_r   <= div_done;
      v5_r   <= v4_r;
      done_r <= v5_r;
      if (v2_r) begin
        prev_r <= e_r;
      end
      if (div_done) begin
        if (acc_sum > 44'(fwts_pkg::ACC_LIM)) begin
          acc_r <= fwts_pkg::ACC_W'(fwts_pkg::ACC_LIM);
        end else if (acc_sum < -44'(fwts_pkg::ACC_LIM)) begin
          acc_r <= fwts_pkg::ACC_W'(-fwts_pkg::ACC_LIM);
        end else begin
          acc_r <= acc_sum[fwts_pkg::ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e_r <= at_w - am_w;
    end
    if (v1_r) begin
      m1_r <= m1_w;
      m2_r <= m2_w;
    end
    if (v2_r) begin
      neg_r <= x7_w[42];
    end
    if (v4_r) begin
      t_r <= a10_w[42:16];
    end
    if (v5_r) begin
      duty_r <= (d_w > DMAX) ? fwts_pkg::DUTY_W'(DMAX) : fwts_pkg::DUTY_W'(d_w);
    end
  end

  assign done = done_r;
  assign duty = duty_r;
endmodule

>>> design/fwts_checker.sv
// port-level checks of the controller top level, with its bind
module fwts_checker #(
  parameter int DUTY_MAX = 10000
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_duty_0,
  input logic [3:0]  out_direction_bits
);
  localparam logic [16:0] DMAX = 17'(DUTY_MAX);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_direction_bits))
    else $error("stalled result changed");

  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {3'd0, out_duty_0} <= DMAX)
    else $error("duty above maximum");
endmodule

bind four_wheel_trace_speed_pid_core fwts_checker #(.DUTY_MAX(DUTY_MAX)) u_fwts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_duty_0         (out_duty_0),
  .out_direction_bits (out_direction_bits)
);
